FILE: sv/hfa_pkg.sv
`default_nettype none
package hfa_pkg;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] RM_RNE = 2'd0;
  localparam logic [1:0] RM_RTZ = 2'd1;
  localparam logic [1:0] RM_RUP = 2'd2;
  localparam logic [1:0] RM_RDN = 2'd3;

  localparam logic [15:0] QNAN_CANON = 16'h7E00;
  localparam logic [15:0] EXP_MASK   = 16'h7C00;
  localparam logic [15:0] MAX_FINITE = 16'h7BFF;

  localparam int QueueDepthDefault = 2;

  // Width of the significand handed to the rounder, and its quotient width.
  // An aligned sum can reach 41 bits when the exponents differ by 29.
  localparam int SigW = 48;
  localparam int QuoW = 27;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROUND,
    ST_OUT
  } be_state_t;

  // Classified operation passed from the front end to the back end.
  typedef struct packed {
    logic [1:0]  cmd;          // add/mul/div (sub folded into add)
    logic        special;      // result is fully decided by the front end
    logic [15:0] spec_val;
    logic        spec_nv;
    logic        spec_dz;
    logic        sign;         // sign of a for add, of the result for mul/div
    logic        sign_b;       // sign of b after the subtract flip
    logic [10:0] ma;
    logic [10:0] mb;
    logic signed [6:0] ea;
    logic signed [6:0] eb;
  } hfa_op_t;

  typedef struct packed {
    logic [15:0] value;
    logic nx;
    logic of;
    logic uf;
    logic dz;
    logic nv;
  } hfa_res_t;

endpackage
`default_nettype wire

FILE: sv/hfa_front.sv
`default_nettype none
module hfa_front (
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [15:0] in_operand_a,
  input  wire logic [15:0] in_operand_b,
  input  wire logic [1:0]  rmode,
  output logic             op_valid,
  input  wire logic        op_ready,
  output hfa_pkg::hfa_op_t op_data
);

  logic [15:0] a, b;
  logic a_nan, b_nan, a_snan, b_snan, a_inf, b_inf, a_zero, b_zero;
  logic sa, sb, sx;
  logic [3:0] la, lb;
  hfa_pkg::hfa_op_t op;

  assign in_ready = op_ready;
  assign op_valid = in_valid;
  assign op_data  = op;

  always_comb begin
    a = in_operand_a;
    b = (in_command == hfa_pkg::CMD_SUB) ? (in_operand_b ^ 16'h8000) : in_operand_b;
    a_nan  = a[14:0] > hfa_pkg::EXP_MASK[14:0];
    b_nan  = b[14:0] > hfa_pkg::EXP_MASK[14:0];
    a_snan = a_nan && !a[9];
    b_snan = b_nan && !b[9];
    a_inf  = a[14:0] == hfa_pkg::EXP_MASK[14:0];
    b_inf  = b[14:0] == hfa_pkg::EXP_MASK[14:0];
    a_zero = a[14:0] == 15'd0;
    b_zero = b[14:0] == 15'd0;
    sa = a[15];
    sb = b[15];
    sx = sa ^ sb;

    op = '0;
    op.cmd = (in_command == hfa_pkg::CMD_SUB) ? hfa_pkg::CMD_ADD : in_command;
    op.ma = (a[14:10] == 5'd0) ? {1'b0, a[9:0]} : {1'b1, a[9:0]};
    op.mb = (b[14:10] == 5'd0) ? {1'b0, b[9:0]} : {1'b1, b[9:0]};
    op.ea = (a[14:10] == 5'd0) ? 7'sd1 : $signed({2'b00, a[14:10]});
    op.eb = (b[14:10] == 5'd0) ? 7'sd1 : $signed({2'b00, b[14:10]});
    op.sign = (op.cmd == hfa_pkg::CMD_ADD) ? sa : sx;
    op.sign_b = sb;

    // Divide operands are normalized so that the quotient has a fixed width.
    la = '0;
    lb = '0;
    for (int i = 0; i < 11; i++) begin
      if (op.ma[i]) begin
        la = 4'(10 - i);
      end
      if (op.mb[i]) begin
        lb = 4'(10 - i);
      end
    end
    if (op.cmd == hfa_pkg::CMD_DIV) begin
      op.ma = op.ma << la;
      op.mb = op.mb << lb;
      op.ea = op.ea - $signed({3'b000, la});
      op.eb = op.eb - $signed({3'b000, lb});
    end

    if (a_nan || b_nan) begin
      op.special  = 1'b1;
      op.spec_val = hfa_pkg::QNAN_CANON;
      op.spec_nv  = a_snan || b_snan;
    end else begin
      unique case (op.cmd)
        hfa_pkg::CMD_MUL: begin
          if (a_inf || b_inf) begin
            op.special = 1'b1;
            if (a_zero || b_zero) begin
              op.spec_val = hfa_pkg::QNAN_CANON;
              op.spec_nv  = 1'b1;
            end else begin
              op.spec_val = {sx, 15'h7C00};
            end
          end else if (a_zero || b_zero) begin
            op.special  = 1'b1;
            op.spec_val = {sx, 15'd0};
          end
        end
        hfa_pkg::CMD_DIV: begin
          if (a_inf) begin
            op.special = 1'b1;
            if (b_inf) begin
              op.spec_val = hfa_pkg::QNAN_CANON;
              op.spec_nv  = 1'b1;
            end else begin
              op.spec_val = {sx, 15'h7C00};
            end
          end else if (b_inf) begin
            op.special  = 1'b1;
            op.spec_val = {sx, 15'd0};
          end else if (b_zero) begin
            op.special = 1'b1;
            if (a_zero) begin
              op.spec_val = hfa_pkg::QNAN_CANON;
              op.spec_nv  = 1'b1;
            end else begin
              op.spec_val = {sx, 15'h7C00};
              op.spec_dz  = 1'b1;
            end
          end else if (a_zero) begin
            op.special  = 1'b1;
            op.spec_val = {sx, 15'd0};
          end
        end
        default: begin
          if (a_inf || b_inf) begin
            op.special = 1'b1;
            if (a_inf && b_inf && (sa != sb)) begin
              op.spec_val = hfa_pkg::QNAN_CANON;
              op.spec_nv  = 1'b1;
            end else begin
              op.spec_val = a_inf ? a : b;
            end
          end else if (a_zero && b_zero) begin
            op.special  = 1'b1;
            op.spec_val = (sa == sb) ? {sa, 15'd0}
                        : {(rmode == hfa_pkg::RM_RDN), 15'd0};
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/hfa_queue.sv
`default_nettype none
module hfa_queue #(
  parameter int Depth = hfa_pkg::QueueDepthDefault
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire hfa_pkg::hfa_op_t wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output hfa_pkg::hfa_op_t      rd_data
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  hfa_pkg::hfa_op_t mem_r [Depth];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic wr_fire, rd_fire;

  assign wr_ready = cnt_r != Depth[AW:0];
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (wr_fire) begin
      wp_nxt = (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
    end
    if (rd_fire) begin
      rp_nxt = (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
    end
    cnt_nxt = cnt_r + {{AW{1'b0}}, wr_fire} - {{AW{1'b0}}, rd_fire};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

FILE: sv/hfa_back.sv
`default_nettype none
module hfa_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [1:0]       rmode,
  input  wire logic             op_valid,
  output logic                  op_ready,
  input  wire hfa_pkg::hfa_op_t op_data,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output hfa_pkg::hfa_res_t     res_data
);

  localparam int SW = hfa_pkg::SigW;
  localparam int QW = hfa_pkg::QuoW;

  hfa_pkg::be_state_t state_r, state_nxt;

  logic [SW-1:0]      sig_r, sig_nxt;
  logic signed [8:0]  exp_r, exp_nxt;   // value = sig * 2^exp
  logic               stk_r, stk_nxt;
  logic               sign_r, sign_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic [11:0]        rem_r, rem_nxt;
  logic [10:0]        dvs_r, dvs_nxt;
  hfa_pkg::hfa_res_t  res_r, res_nxt;

  // Front-side operand alignment for add, the multiply product and the divide step.
  logic signed [6:0] emin;
  logic [5:0]        dea, deb;
  logic [SW-1:0]     xa, xb;
  logic [21:0]       prod;
  logic [12:0]       rem_sub;

  // Rounding.
  logic [5:0]        lz;
  logic [5:0]        p;
  logic signed [9:0] q, sh, ptop;
  logic [SW-1:0]     kept;
  logic [11:0]       kr;
  logic              guard, rest, inexact, inc, tiny;
  logic signed [9:0] be;
  logic              to_inf;
  logic [SW-1:0]     lowmask;

  always_comb begin
    emin = (op_data.ea < op_data.eb) ? op_data.ea : op_data.eb;
    dea  = 6'(op_data.ea - emin);
    deb  = 6'(op_data.eb - emin);
    xa   = SW'(op_data.ma) << dea;
    xb   = SW'(op_data.mb) << deb;
    prod = op_data.ma * op_data.mb;
    rem_sub = {1'b0, rem_r} - {2'b00, dvs_r};
  end

  always_comb begin
    lz = '0;
    for (int i = 0; i < SW; i++) begin
      if (sig_r[i]) begin
        lz = 6'(i);
      end
    end
    p    = lz;
    ptop = $signed({4'b0, p}) + 10'(exp_r);
    q    = ptop - 10'sd10;
    if (q < -10'sd24) begin
      q = -10'sd24;
    end
    sh   = q - 10'(exp_r);
    tiny = ptop < -10'sd14;
    lowmask = '0;
    if (sh <= 0) begin
      kept  = sig_r << 5'(-sh);
      guard = 1'b0;
      rest  = stk_r;
    end else if (sh > 10'(SW)) begin
      kept  = '0;
      guard = 1'b0;
      rest  = 1'b1;
    end else begin
      kept    = sig_r >> sh[5:0];
      guard   = sig_r[6'(sh - 1)];
      lowmask = (SW'(1) << 6'(sh - 1)) - SW'(1);
      rest    = ((sig_r & lowmask) != '0) || stk_r;
    end
    inexact = guard || rest;
    case (rmode)
      hfa_pkg::RM_RNE: inc = guard && (rest || kept[0]);
      hfa_pkg::RM_RTZ: inc = 1'b0;
      hfa_pkg::RM_RUP: inc = inexact && !sign_r;
      default:         inc = inexact && sign_r;
    endcase
    kr = kept[11:0] + {11'd0, inc};
    if (kr[11]) begin
      kr = kr >> 1;
      q  = q + 10'sd1;
    end
    be = kr[10] ? q + 10'sd25 : 10'sd0;
    to_inf = (rmode == hfa_pkg::RM_RNE) || (rmode == hfa_pkg::RM_RUP && !sign_r)
          || (rmode == hfa_pkg::RM_RDN && sign_r);
  end

  always_comb begin
    state_nxt = state_r;
    sig_nxt = sig_r;
    exp_nxt = exp_r;
    stk_nxt = stk_r;
    sign_nxt = sign_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    res_nxt = res_r;
    op_ready = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      hfa_pkg::ST_IDLE: begin
        op_ready = 1'b1;
        if (op_valid) begin
          sign_nxt = op_data.sign;
          stk_nxt  = 1'b0;
          res_nxt  = '0;
          if (op_data.special) begin
            res_nxt.value = op_data.spec_val;
            res_nxt.nv    = op_data.spec_nv;
            res_nxt.dz    = op_data.spec_dz;
            state_nxt     = hfa_pkg::ST_OUT;
          end else if (op_data.cmd == hfa_pkg::CMD_MUL) begin
            sig_nxt   = SW'(prod);
            exp_nxt   = 9'(op_data.ea + op_data.eb) - 9'sd50;
            state_nxt = hfa_pkg::ST_ROUND;
          end else if (op_data.cmd == hfa_pkg::CMD_DIV) begin
            // Restoring division of ma*2^26 by mb, one quotient bit a cycle.
            // Both significands arrive normalized, so ma < 2*mb.
            sig_nxt   = '0;
            rem_nxt   = {1'b0, op_data.ma};
            dvs_nxt   = op_data.mb;
            exp_nxt   = 9'(op_data.ea - op_data.eb) - 9'sd26;
            cnt_nxt   = 5'd0;
            state_nxt = hfa_pkg::ST_DIV;
          end else begin
            // Add: the operand with the larger aligned magnitude sets the sign.
            exp_nxt = 9'(emin) - 9'sd25;
            if (op_data.sign == op_data.sign_b) begin
              sig_nxt = xa + xb;
            end else if (xa > xb) begin
              sig_nxt = xa - xb;
            end else if (xb > xa) begin
              sig_nxt  = xb - xa;
              sign_nxt = op_data.sign_b;
            end else begin
              sig_nxt = '0;
            end
            if (sig_nxt == '0) begin
              res_nxt.value = {(rmode == hfa_pkg::RM_RDN), 15'd0};
              state_nxt     = hfa_pkg::ST_OUT;
            end else begin
              state_nxt = hfa_pkg::ST_ROUND;
            end
          end
        end
      end
      hfa_pkg::ST_DIV: begin
        // Quotient needs QW bits (ma*2^26/mb < 2^27).
        if (rem_sub[12]) begin
          sig_nxt = {sig_r[SW-2:0], 1'b0};
          rem_nxt = {rem_r[10:0], 1'b0};
        end else begin
          sig_nxt = {sig_r[SW-2:0], 1'b1};
          rem_nxt = {rem_sub[10:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(QW - 1)) begin
          stk_nxt   = rem_sub[12] ? (rem_r != '0) : (rem_sub[11:0] != '0);
          state_nxt = hfa_pkg::ST_ROUND;
        end
      end
      hfa_pkg::ST_ROUND: begin
        res_nxt = '0;
        res_nxt.nx = inexact;
        res_nxt.uf = inexact && tiny;
        if (be >= 10'sd31) begin
          res_nxt.of    = 1'b1;
          res_nxt.nx    = 1'b1;
          res_nxt.value = {sign_r, to_inf ? 15'h7C00 : hfa_pkg::MAX_FINITE[14:0]};
        end else begin
          res_nxt.value = {sign_r, be[4:0], kr[9:0]};
        end
        state_nxt = hfa_pkg::ST_OUT;
      end
      hfa_pkg::ST_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = hfa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hfa_pkg::ST_IDLE;
    endcase
  end

  assign res_data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hfa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sig_r  <= sig_nxt;
    exp_r  <= exp_nxt;
    stk_r  <= stk_nxt;
    sign_r <= sign_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    res_r  <= res_nxt;
  end

endmodule
`default_nettype wire

FILE: sv/half_float_arith_unit_core.sv
// Flow: each accepted word waits in the queue until the idle back end takes it. Special
// operands and exact zero sums then go straight to the output state; add/sub and
// multiply pass through the rounding state, and divide runs 27 restoring steps, one
// quotient bit a cycle, before rounding. The back end holds one word at a time and
// takes no new one until its result is out; the queue keeps taking words meanwhile.
// Reset: rst_n is synchronous and active low; it empties the queue, idles the
// back end and sets the rounding mode to nearest-even.
`default_nettype none
module half_float_arith_unit_core #(
  parameter int QueueDepth = hfa_pkg::QueueDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [15:0] in_operand_a,
  input  wire logic [15:0] in_operand_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_result_value,
  output logic             out_flag_inexact,
  output logic             out_flag_overflow,
  output logic             out_flag_underflow,
  output logic             out_flag_div_by_zero,
  output logic             out_flag_invalid,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // The rounding mode register is the only configuration state.
  logic [1:0] rmode_r, rmode_nxt;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {30'd0, rmode_r} : 32'd0;

  always_comb begin
    rmode_nxt = rmode_r;
    if (psel && penable && pwrite && paddr == 2'd0) begin
      rmode_nxt = pwdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rmode_r <= hfa_pkg::RM_RNE;
    end else begin
      rmode_r <= rmode_nxt;
    end
  end

  hfa_pkg::hfa_op_t  f_op, q_op;
  hfa_pkg::hfa_res_t res;
  logic f_valid, f_ready, q_valid, q_ready;

  // The front end classifies each word and folds subtraction into add.
  hfa_front u_front (
    .in_valid, .in_ready, .in_command, .in_operand_a, .in_operand_b,
    .rmode(rmode_r), .op_valid(f_valid), .op_ready(f_ready), .op_data(f_op)
  );

  // Short queue so the front can take words while the back end divides.
  hfa_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_op),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_op)
  );

  hfa_back u_back (
    .clk, .rst_n, .rmode(rmode_r), .op_valid(q_valid), .op_ready(q_ready),
    .op_data(q_op), .res_valid(out_valid), .res_ready(out_ready), .res_data(res)
  );

  assign out_result_value     = res.value;
  assign out_flag_inexact     = res.nx;
  assign out_flag_overflow    = res.of;
  assign out_flag_underflow   = res.uf;
  assign out_flag_div_by_zero = res.dz;
  assign out_flag_invalid     = res.nv;

`ifndef SYNTHESIS
  a_of_implies_nx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flag_overflow |-> out_flag_inexact)
    else $error("overflow without inexact");
  a_uf_implies_nx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flag_underflow |-> out_flag_inexact)
    else $error("underflow without inexact");
  a_nv_gives_nan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flag_invalid |-> out_result_value == hfa_pkg::QNAN_CANON)
    else $error("invalid without canonical NaN");
`endif

endmodule
`default_nettype wire
